### src/khcg_pkg.sv
// Package for the keyed hop channel generator: command and status types,
// controller states, register indexes and SHA-256 constants and helpers.
// No dependencies.
`default_nettype none
package khcg_pkg;

  localparam int unsigned KeyWidth  = 64;
  localparam int unsigned ChanWidth = 8;
  localparam int unsigned IdxWidth  = 3;

  localparam logic [IdxWidth-1:0] REG_KEY0     = 3'd0;
  localparam logic [IdxWidth-1:0] REG_KEY1     = 3'd1;
  localparam logic [IdxWidth-1:0] REG_KEY2     = 3'd2;
  localparam logic [IdxWidth-1:0] REG_KEY3     = 3'd3;
  localparam logic [IdxWidth-1:0] REG_NUM_CHAN = 3'd4;

  localparam logic [31:0] IPAD_WORD = 32'h3636_3636;
  localparam logic [31:0] OPAD_WORD = 32'h5c5c_5c5c;
  localparam logic [31:0] PAD_ONE   = 32'h8000_0000;
  localparam logic [31:0] LEN_INNER = 32'h0000_0220;
  localparam logic [31:0] LEN_OUTER = 32'h0000_0300;

  typedef enum logic [1:0] {
    BLK_INNER_KEY  = 2'd0,
    BLK_INNER_MSG  = 2'd1,
    BLK_OUTER_KEY  = 2'd2,
    BLK_OUTER_MSG  = 2'd3
  } blk_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FINAL,
    S_MOD_START,
    S_MOD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic zero;
    logic load;
    blk_t blk;
    logic round;
    logic final_add;
    logic mod_start;
    logic mod_step;
  } cmd_t;

  typedef struct packed {
    logic chans_zero;
    logic round_last;
    logic mod_last;
  } status_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    case (i)
      3'd0:    init_h = 32'h6a09e667;
      3'd1:    init_h = 32'hbb67ae85;
      3'd2:    init_h = 32'h3c6ef372;
      3'd3:    init_h = 32'ha54ff53a;
      3'd4:    init_h = 32'h510e527f;
      3'd5:    init_h = 32'h9b05688c;
      3'd6:    init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    case (i)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage
`default_nettype wire

### src/khcg_datapath.sv
// Datapath: one shared SHA-256 round unit with its message schedule,
// chaining and inner digest registers, and a bit-serial remainder unit.
// Depends on khcg_pkg.
`default_nettype none
module khcg_datapath (
  input  wire                          clk,
  input  wire                          rst_n,
  input  khcg_pkg::cmd_t               cmd,
  output khcg_pkg::status_t            status,
  input  wire  [31:0]                  frame_number,
  input  wire  [4*khcg_pkg::KeyWidth-1:0] key,
  input  wire  [khcg_pkg::ChanWidth-1:0]  num_channels,
  output logic [khcg_pkg::ChanWidth-1:0]  hop_channel
);
  import khcg_pkg::*;

  logic [31:0] frame_r;
  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] inner_r [8];
  logic [31:0] blk_word [16];
  logic [31:0] sum [8];
  blk_t        blk_r;
  logic [5:0]  cnt_r;
  logic [15:0] div_r;
  logic [8:0]  rem_r;
  logic [8:0]  rem_shift;
  logic [3:0]  mcnt_r;
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2, sched;

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      case (cmd.blk)
        BLK_INNER_KEY: begin
          blk_word[j] = (j < 8) ? (key[255-32*j -: 32] ^ IPAD_WORD) : IPAD_WORD;
        end
        BLK_INNER_MSG: begin
          blk_word[j] = (j == 0) ? {frame_r[7:0], frame_r[15:8], frame_r[23:16],
                                    frame_r[31:24]} :
                        (j == 1) ? PAD_ONE : (j == 15) ? LEN_INNER : 32'd0;
        end
        BLK_OUTER_KEY: begin
          blk_word[j] = (j < 8) ? (key[255-32*j -: 32] ^ OPAD_WORD) : OPAD_WORD;
        end
        default: begin
          blk_word[j] = (j < 8) ? inner_r[j[2:0]] :
                        (j == 8) ? PAD_ONE : (j == 15) ? LEN_OUTER : 32'd0;
        end
      endcase
    end
  end

  always_comb begin
    big_s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch     = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1     = v_r[7] + big_s1 + ch + round_k(cnt_r) + w_r[0];
    big_s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2     = big_s0 + maj;
    sched  = w_r[0] + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[9]
           + (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10));
    for (int i = 0; i < 8; i++) begin
      sum[i] = h_r[i] + v_r[i];
    end
    for (int i = 0; i < 8; i++) begin
      h_nxt[i] = h_r[i];
      v_nxt[i] = v_r[i];
    end
    for (int j = 0; j < 16; j++) begin
      w_nxt[j] = w_r[j];
    end
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) begin
        if (cmd.blk == BLK_INNER_KEY || cmd.blk == BLK_OUTER_KEY) begin
          h_nxt[i] = init_h(i[2:0]);
          v_nxt[i] = init_h(i[2:0]);
        end else begin
          v_nxt[i] = h_r[i];
        end
      end
      for (int j = 0; j < 16; j++) begin
        w_nxt[j] = blk_word[j];
      end
    end else if (cmd.round) begin
      v_nxt[0] = t1 + t2;
      v_nxt[1] = v_r[0];
      v_nxt[2] = v_r[1];
      v_nxt[3] = v_r[2];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[5] = v_r[4];
      v_nxt[6] = v_r[5];
      v_nxt[7] = v_r[6];
      for (int j = 0; j < 15; j++) begin
        w_nxt[j] = w_r[j+1];
      end
      w_nxt[15] = sched;
    end else if (cmd.final_add) begin
      for (int i = 0; i < 8; i++) begin
        h_nxt[i] = sum[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      h_r[i] <= h_nxt[i];
      v_r[i] <= v_nxt[i];
    end
    for (int j = 0; j < 16; j++) begin
      w_r[j] <= w_nxt[j];
    end
    if (cmd.capture) begin
      frame_r <= frame_number;
    end
    if (cmd.load) begin
      blk_r <= cmd.blk;
    end
    if (cmd.final_add && blk_r == BLK_INNER_MSG) begin
      for (int i = 0; i < 8; i++) begin
        inner_r[i] <= sum[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.round) begin
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign rem_shift = {rem_r[7:0], div_r[15]};

  always_ff @(posedge clk) begin
    if (cmd.zero) begin
      rem_r <= '0;
    end else if (cmd.mod_start) begin
      rem_r  <= '0;
      div_r  <= {h_r[0][23:16], h_r[0][31:24]};
      mcnt_r <= '0;
    end else if (cmd.mod_step) begin
      rem_r  <= (rem_shift >= {1'b0, num_channels}) ? rem_shift - {1'b0, num_channels}
                                                    : rem_shift;
      div_r  <= {div_r[14:0], 1'b0};
      mcnt_r <= mcnt_r + 4'd1;
    end
  end

  assign status.chans_zero = (num_channels == '0);
  assign status.round_last = (cnt_r == 6'd63);
  assign status.mod_last   = (mcnt_r == 4'd15);
  assign hop_channel       = rem_r[7:0];

endmodule
`default_nettype wire

### src/khcg_ctrl.sv
// Controller: sequences the four compressions of one keyed hash and the
// remainder, and runs the input and result handshakes. Depends on khcg_pkg.
`default_nettype none
module khcg_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  khcg_pkg::status_t  status,
  output khcg_pkg::cmd_t     cmd
);
  import khcg_pkg::*;

  state_t state_r, state_nxt;
  blk_t   blk_r, blk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      blk_r   <= BLK_INNER_KEY;
    end else begin
      state_r <= state_nxt;
      blk_r   <= blk_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    cmd       = '0;
    cmd.blk   = blk_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          blk_nxt     = BLK_INNER_KEY;
          if (status.chans_zero) begin
            cmd.zero  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (status.round_last) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.final_add = 1'b1;
        if (blk_r == BLK_OUTER_MSG) begin
          state_nxt = S_MOD_START;
        end else begin
          blk_nxt   = blk_t'(blk_r + 2'd1);
          state_nxt = S_LOAD;
        end
      end
      S_MOD_START: begin
        cmd.mod_start = 1'b1;
        state_nxt     = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_hash_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !status.chans_zero |=> state_r == S_LOAD && blk_r == BLK_INNER_KEY)
    else $error("hash did not start after a transfer");

  a_round_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND && status.round_last |=> state_r == S_FINAL)
    else $error("compression did not finish after its last round");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("block not idle after result transfer");

endmodule
`default_nettype wire

### src/keyed_hop_channel_generator_unit.sv
// Top level of the keyed hop channel generator: configuration registers,
// controller and datapath. Depends on khcg_pkg, khcg_ctrl and khcg_datapath.
//
// Each frame number is hashed with HMAC-SHA256 under the 32-byte network key,
// and the first two digest bytes, read little-endian, modulo the channel count
// give the hop channel. One item is processed at a time: with a nonzero channel
// count the single shared SHA-256 round unit runs four compressions of 64
// rounds plus a load and a final add each, followed by a bit-serial remainder
// over the 16-bit digest value. With a channel count of zero the result is 0
// and is offered in the cycle after the transfer. Configuration is to be written
// by the user only while the block is idle; the block itself does not enforce it.
`default_nettype none
module keyed_hop_channel_generator_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [31:0]                       in_frame_number,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [khcg_pkg::ChanWidth-1:0]    out_hop_channel,
  input  wire                               cfg_we,
  input  wire  [khcg_pkg::IdxWidth-1:0]     cfg_index,
  input  wire  [khcg_pkg::KeyWidth-1:0]     cfg_data
);
  import khcg_pkg::*;

  logic [KeyWidth-1:0]  key0_r, key1_r, key2_r, key3_r;
  logic [ChanWidth-1:0] chans_r;
  cmd_t                 cmd;
  status_t              status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r  <= '0;
      key1_r  <= '0;
      key2_r  <= '0;
      key3_r  <= '0;
      chans_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0:     key0_r  <= cfg_data;
        REG_KEY1:     key1_r  <= cfg_data;
        REG_KEY2:     key2_r  <= cfg_data;
        REG_KEY3:     key3_r  <= cfg_data;
        REG_NUM_CHAN: chans_r <= cfg_data[ChanWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  khcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  khcg_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .frame_number (in_frame_number),
    .key          ({key0_r, key1_r, key2_r, key3_r}),
    .num_channels (chans_r),
    .hop_channel  (out_hop_channel)
  );

endmodule
`default_nettype wire
